// File: rtl/crc_fac_pkg.sv
// package for the crc16 frame append/check block
// holds the result item type, action codes and the crc-16/arc byte update
// no dependencies
`default_nettype none

package crc_fac_pkg;

   // action codes, latched from the first byte of a frame
   localparam logic ACT_GENERATE = 1'b0;
   localparam logic ACT_CHECK    = 1'b1;

   // delay line holds the two trailer candidates
   localparam logic [1:0] HELD_FULL = 2'd2;

   // one input item produces up to this many result items
   localparam int MAX_RESULTS = 3;

   // default depth of the result queue
   localparam int QUEUE_DEPTH_DEF = 4;

   // reflected crc-16 polynomial and initial value
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [15:0] CRC_INIT = 16'h0000;

   // one result item
   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       frame_end;
      logic       crc_match;
      logic       too_short;
   } rsp_type;

   // the result items of one input item, packed from slot 0
   typedef struct packed {
      logic [1:0]  count;
      rsp_type [MAX_RESULTS-1:0] slot;
   } rsp_set_type;

   // crc-16/arc update for one byte, lsb first
   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// File: rtl/crc16_frame_append_check_top.sv
// top level of the crc16 frame append/check block
// instantiates the frame state and the result queue
// depends on crc_fac_pkg, crc_fac_frame, crc_fac_queue
//
// Usage: frame bytes enter on the req_ channel one item per cycle while
// req_stall is low, with req_frame_last on the final byte and req_action
// (0 generate, 1 check) taken from the first byte of each frame. The last
// two bytes of a frame are trailer positions held back in a two-byte delay.
// Each req_ item yields zero to three rsp_ items: in generate mode the
// frame with the trailer replaced by the CRC-16/ARC, high byte first; in
// check mode one item at frame end with rsp_crc_match; a frame of one byte
// gives one item with rsp_too_short.
// Results of an item enter the registered result queue on acceptance.
// Throughput: one req_ item per cycle while each yields at most one result
// and rsp_stall is low; the rsp_ channel moves one item per cycle. A result
// queue of QUEUE_DEPTH items sets this: req_stall rises when it cannot take
// three more items. Reset clears frame state and empties the queue. A
// stalled rsp_ channel holds its item and backs up into req_stall once the
// queue fills.
`default_nettype none

module crc16_frame_append_check_top #(
   parameter int QUEUE_DEPTH = crc_fac_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_action,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_frame_last,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_has_byte,
   output logic            rsp_frame_end,
   output logic            rsp_crc_match,
   output logic            rsp_too_short
);

   logic                       accept;
   logic                       queue_full;
   crc_fac_pkg::rsp_set_type   rsp_set;
   crc_fac_pkg::rsp_type       rsp_item;

   // input handshake
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   crc_fac_frame u_frame (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .action     (req_action),
      .in_byte    (req_in_byte),
      .frame_last (req_frame_last),
      .rsp_set    (rsp_set)
   );

   crc_fac_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_set  (rsp_set),
      .full      (queue_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   // result fields
   assign rsp_out_byte  = rsp_item.out_byte;
   assign rsp_has_byte  = rsp_item.has_byte;
   assign rsp_frame_end = rsp_item.frame_end;
   assign rsp_crc_match = rsp_item.crc_match;
   assign rsp_too_short = rsp_item.too_short;

endmodule

`default_nettype wire

// File: rtl/crc_fac_frame.sv
// frame state for the crc16 frame append/check block
// tracks the trailer delay line and the running crc, forms the result set of each item
// depends on crc_fac_pkg
`default_nettype none

module crc_fac_frame (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      accept,
   input  wire logic                      action,
   input  wire logic [7:0]                in_byte,
   input  wire logic                      frame_last,
   output crc_fac_pkg::rsp_set_type       rsp_set
);

   logic        in_frame_ff, in_frame_in;
   logic        mode_ff, mode_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  held0_ff, held0_in;
   logic [7:0]  held1_ff, held1_in;

   logic        mode;
   logic [1:0]  cnt_cur;
   logic [1:0]  cnt_upd;
   logic [15:0] crc_cur;
   logic [15:0] crc_upd;
   logic        leave;
   logic        emit_leave;
   logic [1:0]  end_count;
   crc_fac_pkg::rsp_type leave_rsp;
   crc_fac_pkg::rsp_type end0_rsp;
   crc_fac_pkg::rsp_type end1_rsp;

   // effective frame state, a new frame starts from reset values
   always_comb begin
      mode    = in_frame_ff ? mode_ff : action;
      cnt_cur = in_frame_ff ? cnt_ff  : 2'd0;
      crc_cur = in_frame_ff ? crc_ff  : crc_fac_pkg::CRC_INIT;
      leave   = (cnt_cur == crc_fac_pkg::HELD_FULL);
   end

   // delay line shift and crc over the byte leaving it
   always_comb begin
      held0_in = held0_ff;
      held1_in = held1_ff;
      crc_upd  = crc_cur;
      cnt_upd  = cnt_cur;
      if (leave) begin
         crc_upd  = crc_fac_pkg::crc_update(crc_cur, held0_ff);
         held0_in = held1_ff;
         held1_in = in_byte;
      end else begin
         if (cnt_cur == 2'd0) begin
            held0_in = in_byte;
         end else begin
            held1_in = in_byte;
         end
         cnt_upd = cnt_cur + 2'd1;
      end
      if (!accept) begin
         held0_in = held0_ff;
         held1_in = held1_ff;
      end
   end

   // result items of this byte
   always_comb begin
      emit_leave = leave && (mode == crc_fac_pkg::ACT_GENERATE);
      leave_rsp  = '{out_byte: held0_ff, has_byte: 1'b1, frame_end: 1'b0,
                     crc_match: 1'b0, too_short: 1'b0};
      end0_rsp   = '0;
      end1_rsp   = '0;
      end_count  = 2'd0;
      if (frame_last) begin
         if (cnt_upd != crc_fac_pkg::HELD_FULL) begin
            end0_rsp.frame_end = 1'b1;
            end0_rsp.too_short = 1'b1;
            end_count = 2'd1;
         end else if (mode == crc_fac_pkg::ACT_GENERATE) begin
            end0_rsp.out_byte  = crc_upd[15:8];
            end0_rsp.has_byte  = 1'b1;
            end1_rsp.out_byte  = crc_upd[7:0];
            end1_rsp.has_byte  = 1'b1;
            end1_rsp.frame_end = 1'b1;
            end_count = 2'd2;
         end else begin
            end0_rsp.frame_end = 1'b1;
            end0_rsp.crc_match = ({held0_in, held1_in} == crc_upd);
            end_count = 2'd1;
         end
      end
      if (emit_leave) begin
         rsp_set.slot[0] = leave_rsp;
         rsp_set.slot[1] = end0_rsp;
         rsp_set.slot[2] = end1_rsp;
         rsp_set.count   = end_count + 2'd1;
      end else begin
         rsp_set.slot[0] = end0_rsp;
         rsp_set.slot[1] = end1_rsp;
         rsp_set.slot[2] = '0;
         rsp_set.count   = end_count;
      end
      if (!accept) begin
         rsp_set.count = 2'd0;
      end
   end

   // next frame state, a frame end returns to reset values
   always_comb begin
      in_frame_in = in_frame_ff;
      mode_in     = mode_ff;
      cnt_in      = cnt_ff;
      crc_in      = crc_ff;
      if (accept) begin
         if (frame_last) begin
            in_frame_in = 1'b0;
            mode_in     = crc_fac_pkg::ACT_GENERATE;
            cnt_in      = 2'd0;
            crc_in      = crc_fac_pkg::CRC_INIT;
         end else begin
            in_frame_in = 1'b1;
            mode_in     = mode;
            cnt_in      = cnt_upd;
            crc_in      = crc_upd;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         mode_ff     <= crc_fac_pkg::ACT_GENERATE;
         cnt_ff      <= 2'd0;
         crc_ff      <= crc_fac_pkg::CRC_INIT;
      end else begin
         in_frame_ff <= in_frame_in;
         mode_ff     <= mode_in;
         cnt_ff      <= cnt_in;
         crc_ff      <= crc_in;
      end
   end

   // delay line bytes, held while no item is accepted
   always_ff @(posedge clock) begin
      held0_ff <= held0_in;
      held1_ff <= held1_in;
   end

endmodule

`default_nettype wire

// File: rtl/crc_fac_queue.sv
// result queue for the crc16 frame append/check block
// takes up to three result items per cycle and hands out one per handshake
// depends on crc_fac_pkg
`default_nettype none

module crc_fac_queue #(
   parameter int QUEUE_DEPTH = crc_fac_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire crc_fac_pkg::rsp_set_type  push_set,
   output logic                           full,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output crc_fac_pkg::rsp_type           rsp_item
);

   localparam int PtrWidth = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntWidth = $clog2(QUEUE_DEPTH + 1);
   localparam int SumWidth = PtrWidth + 2;
   localparam int MaxRes   = crc_fac_pkg::MAX_RESULTS;

   crc_fac_pkg::rsp_type entries_ff [QUEUE_DEPTH];
   logic [PtrWidth-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]  count_ff, count_in;
   logic [PtrWidth-1:0]  wr_addr [MaxRes];
   logic                 pop;

   // pointer plus offset with wrap at the queue depth
   function automatic logic [PtrWidth-1:0] ptr_add(input logic [PtrWidth-1:0] ptr,
                                                   input logic [1:0] offs);
      logic [SumWidth-1:0] sum;
      sum = SumWidth'(ptr) + SumWidth'(offs);
      if (sum >= SumWidth'(QUEUE_DEPTH)) begin
         sum = sum - SumWidth'(QUEUE_DEPTH);
      end
      return sum[PtrWidth-1:0];
   endfunction

   // handshake and head item
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_item  = entries_ff[rd_ptr_ff];
   assign full      = (count_ff > CntWidth'(QUEUE_DEPTH - MaxRes));

   // write addresses of the pushed items
   always_comb begin
      for (int i = 0; i < MaxRes; i++) begin
         wr_addr[i] = ptr_add(wr_ptr_ff, 2'(i));
      end
   end

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = ptr_add(wr_ptr_ff, push_set.count);
      rd_ptr_in = pop ? ptr_add(rd_ptr_ff, 2'd1) : rd_ptr_ff;
      count_in  = count_ff + CntWidth'(push_set.count) - CntWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // item storage
   always_ff @(posedge clock) begin
      for (int i = 0; i < MaxRes; i++) begin
         if (2'(i) < push_set.count) begin
            entries_ff[wr_addr[i]] <= push_set.slot[i];
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/crc_fac_checker.sv
// port checker for the crc16 frame append/check block
// watches the top level ports only, bound to the top level below
// no dependencies
`default_nettype none

module crc_fac_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_has_byte,
   input wire logic       rsp_frame_end,
   input wire logic       rsp_crc_match,
   input wire logic       rsp_too_short
);

   // a stalled result item stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result item dropped while stalled");

   // queue is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result offered after reset");

   // a short frame item is a frame end without a byte
   a_short_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_too_short |-> rsp_frame_end && !rsp_has_byte && !rsp_crc_match)
      else $error("malformed too short item");

   // a match flag only stands on a check mode frame end
   a_match_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_crc_match |-> rsp_frame_end && !rsp_has_byte)
      else $error("crc match outside a check frame end");

   // items without a byte carry a zero byte
   a_zero_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_byte |-> rsp_out_byte == 8'h00)
      else $error("byte value on an item without a byte");

endmodule

bind crc16_frame_append_check_top crc_fac_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_byte  (rsp_out_byte),
   .rsp_has_byte  (rsp_has_byte),
   .rsp_frame_end (rsp_frame_end),
   .rsp_crc_match (rsp_crc_match),
   .rsp_too_short (rsp_too_short)
);

`default_nettype wire
